/* sv/gb3_pkg.sv */
// ----------------------------------------------------------------------------
// gb3_pkg
// Shared types and constants for the separable 3x3 Gaussian blur unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gb3_pkg;

  localparam int MAX_LINE  = 2048;
  localparam int ADDR_W    = $clog2(MAX_LINE);
  localparam int CNT_W     = 11;
  localparam int PIX_W     = 8;
  localparam int WEIGHT_W  = 9;
  localparam int CFG_W     = 12;
  localparam int FRAC_W    = 8;
  localparam int SHIFT_W   = 2 * FRAC_W;
  localparam int ROW_W     = PIX_W + WEIGHT_W + 2;
  localparam int PROD_W    = ROW_W + WEIGHT_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int COL_W     = 3 * PIX_W;
  localparam int PAIR_W    = 2 * PIX_W;
  localparam int MIN_DIM   = 3;
  localparam int MAX_FRAME = 2048;

  typedef enum logic [2:0] {
    CFG_LINE_WIDTH  = 3'd0,
    CFG_FRAME_LINES = 3'd1,
    CFG_HW_LEFT     = 3'd2,
    CFG_HW_MID      = 3'd3,
    CFG_HW_RIGHT    = 3'd4,
    CFG_VW_UP       = 3'd5,
    CFG_VW_MID      = 3'd6,
    CFG_VW_DOWN     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic emit;
    logic eol;
    logic eof;
  } ctl_t;

endpackage

`default_nettype wire

/* sv/gb3_ram.sv */
// ----------------------------------------------------------------------------
// gb3_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/gaussian_blur_3x3_separable_unit.sv */
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_separable_unit
// Streaming 3x3 separable Gaussian blur over 8-bit grey pixels.
// ----------------------------------------------------------------------------
// Takes one padded-frame pixel per clock in raster order and gives one blurred
// pixel per clock for every position whose 3x3 neighborhood is complete.
// The two previous lines sit in one 2048 x 16 RAM (upper/lower pixel pair per
// column), read when a pixel is accepted and written back from stage 1 as it advances.
// An input word passes stages 1, 2 and 3 and the output register; the
// RAM's single read and write port, each used once per pixel, set the rate of
// one pixel per clock. A stalled output word holds the whole pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_3x3_separable_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] pixel_in
  // output stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata,  // [7:0] blurred_pixel
  output logic             out_tlast,  // end_of_line
  output logic             out_tuser,  // [0] end_of_frame
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  localparam int PW = gb3_pkg::PIX_W;

  // configuration
  logic [gb3_pkg::CFG_W-1:0]    line_width_r, frame_lines_r;
  logic [gb3_pkg::WEIGHT_W-1:0] hw_r [3];
  logic [gb3_pkg::WEIGHT_W-1:0] vw_r [3];

  // position counters
  logic [gb3_pkg::CNT_W-1:0] col_cnt_r, line_cnt_r;
  logic [gb3_pkg::CNT_W-1:0] width_m1, height_m1, col_eff;
  logic                      last_col, last_line, accept, adv;

  // pipeline
  gb3_pkg::ctl_t                s1_ctl_r, s2_ctl_r, s3_ctl_r;
  logic [PW-1:0]                s1_pix_r;
  logic [gb3_pkg::ADDR_W-1:0]   s1_idx_r;
  logic [gb3_pkg::COL_W-1:0]    win0_r, win1_r, cur;
  logic [gb3_pkg::ROW_W-1:0]    row_nxt [3];
  logic [gb3_pkg::ROW_W-1:0]    s2_row_r [3];
  logic [gb3_pkg::PROD_W-1:0]   s3_prod_r [3];
  logic [gb3_pkg::ACC_W-1:0]    acc;
  logic [PW-1:0]                pix_sat;
  logic                         out_valid_r, out_eol_r, out_eof_r;
  logic [PW-1:0]                out_pix_r;

  // line store
  logic                         ram_we;
  logic [gb3_pkg::PAIR_W-1:0]   ram_rdata;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r  <= gb3_pkg::CFG_W'(642);
      frame_lines_r <= gb3_pkg::CFG_W'(482);
      hw_r[0] <= gb3_pkg::WEIGHT_W'(64);
      hw_r[1] <= gb3_pkg::WEIGHT_W'(128);
      hw_r[2] <= gb3_pkg::WEIGHT_W'(64);
      vw_r[0] <= gb3_pkg::WEIGHT_W'(64);
      vw_r[1] <= gb3_pkg::WEIGHT_W'(128);
      vw_r[2] <= gb3_pkg::WEIGHT_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      case (gb3_pkg::cfg_reg_t'(cfg_index))
        gb3_pkg::CFG_LINE_WIDTH:  line_width_r  <= cfg_data;
        gb3_pkg::CFG_FRAME_LINES: frame_lines_r <= cfg_data;
        gb3_pkg::CFG_HW_LEFT:     hw_r[0] <= cfg_data[gb3_pkg::WEIGHT_W-1:0];
        gb3_pkg::CFG_HW_MID:      hw_r[1] <= cfg_data[gb3_pkg::WEIGHT_W-1:0];
        gb3_pkg::CFG_HW_RIGHT:    hw_r[2] <= cfg_data[gb3_pkg::WEIGHT_W-1:0];
        gb3_pkg::CFG_VW_UP:       vw_r[0] <= cfg_data[gb3_pkg::WEIGHT_W-1:0];
        gb3_pkg::CFG_VW_MID:      vw_r[1] <= cfg_data[gb3_pkg::WEIGHT_W-1:0];
        gb3_pkg::CFG_VW_DOWN:     vw_r[2] <= cfg_data[gb3_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped dimensions, minus one
  always_comb begin
    if (line_width_r < gb3_pkg::CFG_W'(gb3_pkg::MIN_DIM)) begin
      width_m1 = gb3_pkg::CNT_W'(gb3_pkg::MIN_DIM - 1);
    end else if (line_width_r > gb3_pkg::CFG_W'(gb3_pkg::MAX_LINE)) begin
      width_m1 = gb3_pkg::CNT_W'(gb3_pkg::MAX_LINE - 1);
    end else begin
      width_m1 = gb3_pkg::CNT_W'(line_width_r - 1'b1);
    end
    if (frame_lines_r < gb3_pkg::CFG_W'(gb3_pkg::MIN_DIM)) begin
      height_m1 = gb3_pkg::CNT_W'(gb3_pkg::MIN_DIM - 1);
    end else if (frame_lines_r > gb3_pkg::CFG_W'(gb3_pkg::MAX_FRAME)) begin
      height_m1 = gb3_pkg::CNT_W'(gb3_pkg::MAX_FRAME - 1);
    end else begin
      height_m1 = gb3_pkg::CNT_W'(frame_lines_r - 1'b1);
    end
    col_eff   = (col_cnt_r > width_m1) ? width_m1 : col_cnt_r;
    last_col  = (col_eff == width_m1);
    last_line = (line_cnt_r >= height_m1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      line_cnt_r <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_cnt_r  <= '0;
        line_cnt_r <= last_line ? '0 : line_cnt_r + 1'b1;
      end else begin
        col_cnt_r  <= col_eff + 1'b1;
      end
    end
  end

  // stage 1: line store read issued at accept, data back here
  gb3_ram #(
    .WIDTH (gb3_pkg::PAIR_W),
    .DEPTH (gb3_pkg::MAX_LINE)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_idx_r),
    .wdata ({ram_rdata[PW-1:0], s1_pix_r}),
    .re    (adv),
    .raddr (col_eff[gb3_pkg::ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign ram_we = adv && s1_ctl_r.valid;
  assign cur    = {ram_rdata, s1_pix_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else if (adv) begin
      s1_ctl_r.valid <= accept;
      s1_ctl_r.emit  <= (line_cnt_r >= gb3_pkg::CNT_W'(2)) &&
                        (col_eff >= gb3_pkg::CNT_W'(2));
      s1_ctl_r.eol   <= last_col;
      s1_ctl_r.eof   <= last_col && last_line;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix_r <= in_tdata;
      s1_idx_r <= col_eff[gb3_pkg::ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_r <= '0;
      win1_r <= '0;
    end else if (ram_we) begin
      win1_r <= win0_r;
      win0_r <= cur;
    end
  end

  // horizontal pass: row 0 is the upper line
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      row_nxt[k] =
        gb3_pkg::ROW_W'(hw_r[0]) * gb3_pkg::ROW_W'(win1_r[PW*(2-k) +: PW]) +
        gb3_pkg::ROW_W'(hw_r[1]) * gb3_pkg::ROW_W'(win0_r[PW*(2-k) +: PW]) +
        gb3_pkg::ROW_W'(hw_r[2]) * gb3_pkg::ROW_W'(cur[PW*(2-k) +: PW]);
    end
  end

  // stage 2: row sums; stage 3: vertical products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
    end else if (adv) begin
      s2_ctl_r <= s1_ctl_r;
      s3_ctl_r <= s2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s2_row_r[k]  <= row_nxt[k];
        s3_prod_r[k] <= gb3_pkg::PROD_W'(vw_r[k]) * gb3_pkg::PROD_W'(s2_row_r[k]);
      end
    end
  end

  // final sum, floor and saturate
  always_comb begin
    acc = gb3_pkg::ACC_W'(s3_prod_r[0]) + gb3_pkg::ACC_W'(s3_prod_r[1]) +
          gb3_pkg::ACC_W'(s3_prod_r[2]);
    if (|acc[gb3_pkg::ACC_W-1:gb3_pkg::SHIFT_W+PW]) begin
      pix_sat = '1;
    end else begin
      pix_sat = acc[gb3_pkg::SHIFT_W +: PW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_ctl_r.valid && s3_ctl_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix_r <= pix_sat;
      out_eol_r <= s3_ctl_r.eol;
      out_eof_r <= s3_ctl_r.eof;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_eol_r;
  assign out_tuser  = out_eof_r;

`ifndef SYNTHESIS
  a_eof_has_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("end of frame without end of line");

  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_col |=> col_cnt_r == '0)
    else $error("column counter did not wrap");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s1_ctl_r) && $stable(s2_ctl_r) && $stable(s3_ctl_r))
    else $error("pipeline moved during stall");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the separable 3x3 Gaussian blur unit.
// ----------------------------------------------------------------------------
// Streams padded frames into the unit, predicts every blurred word with a
// behavioral copy of the line stores, column window and counters, and
// compares pixel, end-of-line and end-of-frame of each output word in order.
// Covers clamped and oversized frame sizes, tap masking and saturation,
// resizes in mid-frame, random frames with random taps, random stalls on both
// streams, and one long output hold that backs up the input.
// ----------------------------------------------------------------------------

module tb_top;

  typedef struct packed {
    logic [7:0] pix;
    logic       eol;
    logic       eof;
  } blur_word_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [11:0] cfg_data   = '0;

  // behavioral image of the unit
  logic [11:0]     width_reg = 12'd642;
  logic [11:0]     lines_reg = 12'd482;
  longint unsigned h_tap [3] = '{64, 128, 64};
  longint unsigned v_tap [3] = '{64, 128, 64};
  bit [7:0]        row_up_mem  [gb3_pkg::MAX_LINE];
  bit [7:0]        row_mid_mem [gb3_pkg::MAX_LINE];
  bit [23:0]       win_col [2];
  int unsigned     x_pos;
  int unsigned     y_pos;

  blur_word_t blurred_pending [$];

  bit sender_idle = 1'b1;
  bit sink_idle   = 1'b1;
  int hold_req;
  int mismatches;
  int pixels_in;
  int words_out;
  int frames_out;
  int reg_writes;

  gaussian_blur_3x3_separable_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned eff_dim(logic [11:0] v, int unsigned hi);
    if (v < gb3_pkg::MIN_DIM) return gb3_pkg::MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void apply_reg(gb3_pkg::cfg_reg_t idx, logic [11:0] val);
    case (idx)
      gb3_pkg::CFG_LINE_WIDTH:  width_reg = val;
      gb3_pkg::CFG_FRAME_LINES: lines_reg = val;
      gb3_pkg::CFG_HW_LEFT:     h_tap[0]  = val[gb3_pkg::WEIGHT_W-1:0];
      gb3_pkg::CFG_HW_MID:      h_tap[1]  = val[gb3_pkg::WEIGHT_W-1:0];
      gb3_pkg::CFG_HW_RIGHT:    h_tap[2]  = val[gb3_pkg::WEIGHT_W-1:0];
      gb3_pkg::CFG_VW_UP:       v_tap[0]  = val[gb3_pkg::WEIGHT_W-1:0];
      gb3_pkg::CFG_VW_MID:      v_tap[1]  = val[gb3_pkg::WEIGHT_W-1:0];
      gb3_pkg::CFG_VW_DOWN:     v_tap[2]  = val[gb3_pkg::WEIGHT_W-1:0];
      default: ;
    endcase
  endfunction

  // one accepted pixel: update the image and queue the blurred word it makes
  function automatic void blur_window_step(logic [7:0] pix);
    int unsigned                w;
    int unsigned                h;
    int unsigned                col;
    logic [gb3_pkg::ADDR_W-1:0] idx;
    bit [23:0]                  cur;
    longint unsigned            acc;
    blur_word_t                 res;
    w   = eff_dim(width_reg, gb3_pkg::MAX_LINE);
    h   = eff_dim(lines_reg, gb3_pkg::MAX_FRAME);
    col = (x_pos > w - 1) ? w - 1 : x_pos;
    idx = col[gb3_pkg::ADDR_W-1:0];
    cur = {row_up_mem[idx], row_mid_mem[idx], pix};
    if (y_pos >= 2 && col >= 2) begin
      acc = 0;
      // byte 2 = line above, byte 0 = current line
      for (int k = 0; k < 3; k++) begin
        acc += v_tap[2-k] * (h_tap[0] * win_col[1][8*k +: 8] +
                             h_tap[1] * win_col[0][8*k +: 8] +
                             h_tap[2] * cur[8*k +: 8]);
      end
      acc     = acc >> gb3_pkg::SHIFT_W;
      res.pix = (acc > 255) ? 8'hFF : acc[7:0];
      res.eol = (col == w - 1);
      res.eof = res.eol && (y_pos >= h - 1);
      blurred_pending.push_back(res);
    end
    row_up_mem[idx]  = row_mid_mem[idx];
    row_mid_mem[idx] = pix;
    win_col[1]       = win_col[0];
    win_col[0]       = cur;
    if (col == w - 1) begin
      x_pos = 0;
      y_pos = (y_pos >= h - 1) ? 0 : ((y_pos + 1) & 32'h7FF);
    end else begin
      x_pos = col + 1;
    end
  endfunction

  task automatic send_pixel(logic [7:0] pix);
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    blur_window_step(pix);
    pixels_in++;
  endtask

  // valid stays high so back-to-back writes need no gap; close_cfg lowers it
  task automatic write_reg(gb3_pkg::cfg_reg_t idx, logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    reg_writes++;
  endtask

  task automatic close_cfg();
    cfg_valid <= 1'b0;
  endtask

  // pixels that make no word may still be in flight: allow the pipe depth
  task automatic drain();
    in_tvalid <= 1'b0;
    while (blurred_pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_taps(logic [11:0] side, logic [11:0] mid);
    write_reg(gb3_pkg::CFG_HW_LEFT,  side);
    write_reg(gb3_pkg::CFG_HW_MID,   mid);
    write_reg(gb3_pkg::CFG_HW_RIGHT, side);
    write_reg(gb3_pkg::CFG_VW_UP,    side);
    write_reg(gb3_pkg::CFG_VW_MID,   mid);
    write_reg(gb3_pkg::CFG_VW_DOWN,  side);
  endtask

  task automatic test_directed_extremes();
    drain();
    // width 0 and height 2 both clamp to 3
    write_reg(gb3_pkg::CFG_LINE_WIDTH, 12'd0);
    write_reg(gb3_pkg::CFG_FRAME_LINES, 12'd2);
    close_cfg();
    for (int i = 0; i < 9; i++) send_pixel(i[0] ? 8'hFF : 8'h00);
    drain();
    // upper data bits set: taps mask to 511, all-white input saturates
    set_taps(12'hFFF, 12'hFFF);
    write_reg(gb3_pkg::CFG_LINE_WIDTH, 12'd3);
    write_reg(gb3_pkg::CFG_FRAME_LINES, 12'd3);
    close_cfg();
    for (int i = 0; i < 9; i++) send_pixel(8'hFF);
  endtask

  task automatic test_midframe_resize();
    drain();
    set_taps(12'd64, 12'd128);
    write_reg(gb3_pkg::CFG_LINE_WIDTH, 12'd8);
    write_reg(gb3_pkg::CFG_FRAME_LINES, 12'd6);
    close_cfg();
    for (int i = 0; i < 29; i++) send_pixel(8'($urandom_range(0, 255)));
    drain();
    // column is now past its new last position, line is on its new last line
    write_reg(gb3_pkg::CFG_LINE_WIDTH, 12'd4);
    write_reg(gb3_pkg::CFG_FRAME_LINES, 12'd4);
    close_cfg();
    do send_pixel(8'($urandom_range(0, 255))); while (x_pos != 0 || y_pos != 0);
    do send_pixel(8'($urandom_range(0, 255))); while (x_pos != 0 || y_pos != 0);
  endtask

  task automatic test_output_backpressure();
    drain();
    write_reg(gb3_pkg::CFG_LINE_WIDTH, 12'd16);
    write_reg(gb3_pkg::CFG_FRAME_LINES, 12'd6);
    close_cfg();
    hold_req = 300;
    do send_pixel(8'($urandom_range(0, 255))); while (x_pos != 0 || y_pos != 0);
  endtask

  task automatic test_random_frames();
    int          sent;
    int          n;
    int          half;
    int          mode;
    bit          shrink;
    logic [11:0] val;
    sent = 0;
    while (sent < 150) begin
      sender_idle = ($urandom_range(0, 3) != 0);
      sink_idle   = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) begin
        drain();
        case ($urandom_range(0, 7))
          0:       val = 12'($urandom_range(0, 2));
          1:       val = 12'($urandom_range(25, 64));
          default: val = 12'($urandom_range(3, 12));
        endcase
        write_reg(gb3_pkg::CFG_LINE_WIDTH, val);
        val = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 2)) :
                                            12'($urandom_range(3, 7));
        write_reg(gb3_pkg::CFG_FRAME_LINES, val);
        for (int i = gb3_pkg::CFG_HW_LEFT; i <= gb3_pkg::CFG_VW_DOWN; i++) begin
          case ($urandom_range(0, 5))
            0:       val = 12'd0;
            1:       val = 12'hFFF;
            2:       val = 12'($urandom_range(0, 4095));
            default: val = 12'($urandom_range(0, 128));
          endcase
          write_reg(gb3_pkg::cfg_reg_t'(i), val);
        end
        close_cfg();
      end
      mode   = $urandom_range(0, 3);
      half   = int'(eff_dim(width_reg, gb3_pkg::MAX_LINE) *
                    eff_dim(lines_reg, gb3_pkg::MAX_FRAME) / 2);
      shrink = ($urandom_range(0, 7) == 0);
      n      = 0;
      do begin
        if (mode == 0) send_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00);
        else           send_pixel(8'($urandom_range(0, 255)));
        n++;
        if (shrink && n == half) begin
          // only shrink the line in mid-frame; height may go either way
          drain();
          write_reg(gb3_pkg::CFG_LINE_WIDTH,
                    12'($urandom_range(gb3_pkg::MIN_DIM,
                                       eff_dim(width_reg, gb3_pkg::MAX_LINE))));
          write_reg(gb3_pkg::CFG_FRAME_LINES, 12'($urandom_range(0, 8)));
          close_cfg();
        end
      end while (x_pos != 0 || y_pos != 0);
      sent += n;
    end
  endtask

  task automatic test_max_dimensions();
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    drain();
    set_taps(12'd64, 12'd128);
    // both registers above the 2048 limit; stop partway along the first line
    write_reg(gb3_pkg::CFG_LINE_WIDTH, 12'hFFF);
    write_reg(gb3_pkg::CFG_FRAME_LINES, 12'hFFF);
    close_cfg();
    repeat (40) send_pixel(8'($urandom_range(0, 255)));
    drain();
    // narrower line: the column lands past its new last position
    write_reg(gb3_pkg::CFG_LINE_WIDTH, 12'd5);
    write_reg(gb3_pkg::CFG_FRAME_LINES, 12'd3);
    close_cfg();
    do send_pixel(8'($urandom_range(0, 255))); while (x_pos != 0 || y_pos != 0);
  endtask

  // output side: random stalls, plus one long hold on request
  initial begin : sink_ctrl
    int n;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        n        = hold_req;
        hold_req = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
        out_tready <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    blur_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      words_out++;
      if (out_tuser === 1'b1) frames_out++;
      if (blurred_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected word pix %0d eol %b eof %b",
                   out_tdata, out_tlast, out_tuser);
      end else begin
        want = blurred_pending.pop_front();
        if (want.pix !== out_tdata || want.eol !== out_tlast || want.eof !== out_tuser) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: word %0d expected pix %0d eol %b eof %b, got pix %0d eol %b eof %b",
                     words_out, want.pix, want.eol, want.eof,
                     out_tdata, out_tlast, out_tuser);
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_extremes();
    test_midframe_resize();
    test_output_backpressure();
    test_random_frames();
    test_max_dimensions();
    drain();
    $display("Blur run: %0d pixels in, %0d words out, %0d frames closed, %0d register writes",
             pixels_in, words_out, frames_out, reg_writes);
    $display("Sizes from clamped minimum to oversized registers, taps 0 to 511, %0d mismatches",
             mismatches);
    if (mismatches == 0 && blurred_pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
